@@ design/rscn_pkg.sv @@
// shared widths, codes and payload types of the reflectance sensor calibrate and normalize block
`timescale 1ns / 1ps

package rscn_pkg;

    // sizes
    localparam int DEF_NUM_CHANNELS = 8;
    localparam int BATCH_LENGTH     = 10;
    localparam int CH_W             = 3;
    localparam int RAW_W            = 12;
    localparam int LEVEL_W          = 10;
    localparam int STATUS_W         = 2;
    localparam int MODE_W           = 2;
    localparam int COUNT_W          = 4;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 12;
    // signed working width of combined readings and ranges
    localparam int SPAN_W           = 16;
    // positive numerator and span after clamping checks
    localparam int NUM_W            = 14;
    // numerator times full level
    localparam int PROD_W           = 24;

    localparam int FULL_LEVEL       = 1000;
    localparam int FULL_SCALE_RESET = 1023;

    // operation codes
    localparam logic OP_CAL  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // read modes, the unused code behaves as combined
    localparam logic [MODE_W-1:0] MODE_ON   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_OFF  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BOTH = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_CAL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_CAL     = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_READ_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 1'd1;

    typedef struct packed {
        logic             operation;
        logic [CH_W-1:0]  channel;
        logic [RAW_W-1:0] on_value;
        logic [RAW_W-1:0] off_value;
    } t_item;

    typedef struct packed {
        logic [CH_W-1:0]     out_channel;
        logic [LEVEL_W-1:0]  level;
        logic [STATUS_W-1:0] status;
    } t_result;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } t_cfg_wr;

    // one channel's word in the calibration memory
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [RAW_W-1:0]   low_on;
        logic [RAW_W-1:0]   high_on;
        logic [RAW_W-1:0]   low_off;
        logic [RAW_W-1:0]   high_off;
        logic [RAW_W-1:0]   min_on;
        logic [RAW_W-1:0]   max_on;
        logic [RAW_W-1:0]   min_off;
        logic [RAW_W-1:0]   max_off;
    } t_entry;

endpackage

@@ design/rscn_chan_if.sv @@
// valid/ready channel interface carrying one word of a given type
`timescale 1ns / 1ps

interface rscn_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ design/rscn_div.sv @@
// restoring divider producing the scaled level one quotient bit per cycle
`timescale 1ns / 1ps

module rscn_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [rscn_pkg::PROD_W-1:0]  i_dividend,
    input  logic [rscn_pkg::NUM_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [rscn_pkg::LEVEL_W-1:0] o_quot
);
    localparam int PW = rscn_pkg::PROD_W;
    localparam int QW = rscn_pkg::LEVEL_W;
    localparam int CW = $clog2(QW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] r_rem;
    logic [PW-1:0] r_dsh;
    logic [QW-1:0] r_quot;
    logic [PW:0]   diff;
    logic          fits;

    // trial subtraction of the shifted divisor
    assign diff = {1'b0, r_rem} - {1'b0, r_dsh};
    assign fits = !diff[PW];

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QW - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // datapath, quotient is known to stay below 2^QW
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend;
            r_dsh  <= PW'({i_divisor, {(QW - 1){1'b0}}});
            r_quot <= '0;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= diff[PW-1:0];
            end
            r_quot <= {r_quot[QW-2:0], fits};
            r_dsh  <= r_dsh >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

@@ design/reflectance_sensor_calibrate_normalize.sv @@
// top level: per-channel min/max calibration memory and 0..1000 normalization
`timescale 1ns / 1ps

// Each word is either a calibration sample (operation 0) or a read (operation 1) and gives
// exactly one result word. A calibration sample passes from acceptance through one read of
// the channel's memory word and one write back before the next acceptance. A read that
// needs scaling goes through memory read, range setup, one multiply, the ten-step restoring
// divider that scales the reading to 0..1000 and the hand-off to the output register. An
// uncalibrated read, and a read with an empty span or a reading outside the range, skip
// the divider.
// A finished result waits in the output register while the next word is accepted.
// Configuration writes (read mode, full scale) are taken at any time and are meant to
// be issued while the block is idle. There is no clearing pass after reset.

module reflectance_sensor_calibrate_normalize #(
    parameter int NUM_CHANNELS = rscn_pkg::DEF_NUM_CHANNELS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rscn_chan_if.sink   i_in,
    rscn_chan_if.source o_out,
    rscn_chan_if.sink   i_cfg
);
    localparam int IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int NCH_W  = IDX_W + rscn_pkg::CH_W;
    localparam int RW     = rscn_pkg::RAW_W;
    localparam int SW     = rscn_pkg::SPAN_W;
    localparam int NW     = rscn_pkg::NUM_W;
    localparam int PW     = rscn_pkg::PROD_W;
    localparam int LW     = rscn_pkg::LEVEL_W;
    localparam int CNTW   = rscn_pkg::COUNT_W;
    localparam logic [NCH_W-1:0] NCH = NCH_W'(NUM_CHANNELS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_CALC = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]                    r_state;
    logic [2:0]                    n_state;
    logic [rscn_pkg::MODE_W-1:0]   r_mode;
    logic [RW-1:0]                 r_fs;
    logic                          r_on_valid;
    logic                          r_off_valid;
    logic [RW-1:0]                 r_fill_on;
    logic [RW-1:0]                 r_fill_off;
    logic [NUM_CHANNELS-1:0]       r_on_ent;
    logic [NUM_CHANNELS-1:0]       r_off_ent;
    logic [NUM_CHANNELS-1:0]       r_bat_ent;
    rscn_pkg::t_entry              r_mem [NUM_CHANNELS];
    rscn_pkg::t_entry              r_rd;
    rscn_pkg::t_item               r_item;
    logic [IDX_W-1:0]              r_idx;
    logic                          r_in_range;
    logic signed [SW-1:0]          r_v;
    logic signed [SW-1:0]          r_lo;
    logic signed [SW-1:0]          r_hi;
    logic [rscn_pkg::STATUS_W-1:0] r_status;
    logic [LW-1:0]                 r_level;
    logic [NW-1:0]                 r_num;
    logic [NW-1:0]                 r_den;
    logic [PW-1:0]                 r_prod;
    logic                          r_div_go;
    logic                          r_out_valid;
    rscn_pkg::t_result             r_out;

    logic                 in_acc;
    logic [NCH_W-1:0]     in_ch_wide;
    logic [IDX_W-1:0]     in_idx;
    logic                 in_range;
    logic                 out_load;
    logic                 use_on;
    logic                 use_off;
    logic                 cal_now;
    logic [CNTW-1:0]      eff_count;
    logic [CNTW-1:0]      cnt_inc;
    logic                 first;
    logic                 batch_end;
    logic                 commit_on;
    logic                 commit_off;
    logic [RW-1:0]        lo_on_n;
    logic [RW-1:0]        hi_on_n;
    logic [RW-1:0]        lo_off_n;
    logic [RW-1:0]        hi_off_n;
    logic [RW-1:0]        base_min_on;
    logic [RW-1:0]        base_max_on;
    logic [RW-1:0]        base_min_off;
    logic [RW-1:0]        base_max_off;
    rscn_pkg::t_entry     wr_entry;
    logic                 rd_not_cal;
    logic signed [SW-1:0] sel_v;
    logic signed [SW-1:0] sel_lo;
    logic signed [SW-1:0] sel_hi;
    logic signed [SW-1:0] fs_s;
    logic signed [SW-1:0] calc_num;
    logic signed [SW-1:0] calc_den;
    logic                 calc_zero;
    logic                 calc_sat;
    logic                 div_done;
    logic [LW-1:0]        div_quot;

    // handshakes
    assign in_acc       = i_in.valid && i_in.ready;
    assign i_in.ready   = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign out_load     = (r_state == S_DONE) && (!r_out_valid || o_out.ready);
    assign o_out.valid  = r_out_valid;
    assign o_out.data   = r_out;

    // channel index and range check
    assign in_ch_wide = {{IDX_W{1'b0}}, i_in.data.channel};
    assign in_idx     = in_ch_wide[IDX_W-1:0];
    assign in_range   = in_ch_wide < NCH;

    assign use_on  = (r_mode != rscn_pkg::MODE_OFF);
    assign use_off = (r_mode != rscn_pkg::MODE_ON);
    assign fs_s    = SW'(r_fs);

    // stored ranges as seen through the per-entry and table valid bits
    assign base_min_on  = r_on_ent[r_idx] ? r_rd.min_on :
                          (r_on_valid ? r_fill_on : r_fs);
    assign base_max_on  = r_on_ent[r_idx] ? r_rd.max_on : '0;
    assign base_min_off = r_off_ent[r_idx] ? r_rd.min_off :
                          (r_off_valid ? r_fill_off : r_fs);
    assign base_max_off = r_off_ent[r_idx] ? r_rd.max_off : '0;

    // batch tracking and end-of-batch commit
    assign cal_now   = (r_state == S_READ) && (r_item.operation == rscn_pkg::OP_CAL)
                       && r_in_range;
    assign eff_count = r_bat_ent[r_idx] ? r_rd.count : '0;
    assign first     = (eff_count == '0);
    assign cnt_inc   = eff_count + 1'b1;
    assign batch_end = (cnt_inc >= CNTW'(rscn_pkg::BATCH_LENGTH));
    assign commit_on  = batch_end && use_on;
    assign commit_off = batch_end && use_off;

    assign lo_on_n  = (first || r_item.on_value < r_rd.low_on) ? r_item.on_value : r_rd.low_on;
    assign hi_on_n  = (first || r_item.on_value > r_rd.high_on) ? r_item.on_value
                                                                 : r_rd.high_on;
    assign lo_off_n = (first || r_item.off_value < r_rd.low_off) ? r_item.off_value
                                                                  : r_rd.low_off;
    assign hi_off_n = (first || r_item.off_value > r_rd.high_off) ? r_item.off_value
                                                                   : r_rd.high_off;

    // word written back for a calibration sample
    always_comb begin
        wr_entry          = r_rd;
        wr_entry.count    = batch_end ? '0 : cnt_inc;
        wr_entry.low_on   = lo_on_n;
        wr_entry.high_on  = hi_on_n;
        wr_entry.low_off  = lo_off_n;
        wr_entry.high_off = hi_off_n;
        wr_entry.min_on   = (commit_on && hi_on_n < base_min_on) ? hi_on_n : base_min_on;
        wr_entry.max_on   = (commit_on && lo_on_n > base_max_on) ? lo_on_n : base_max_on;
        wr_entry.min_off  = (commit_off && hi_off_n < base_min_off) ? hi_off_n : base_min_off;
        wr_entry.max_off  = (commit_off && lo_off_n > base_max_off) ? lo_off_n : base_max_off;
    end

    // read path: pick reading and range by mode
    assign rd_not_cal = !r_in_range || (use_on && !r_on_valid) || (use_off && !r_off_valid);

    always_comb begin
        case (r_mode)
            rscn_pkg::MODE_ON: begin
                sel_v  = SW'(r_item.on_value);
                sel_lo = SW'(base_min_on);
                sel_hi = SW'(base_max_on);
            end
            rscn_pkg::MODE_OFF: begin
                sel_v  = SW'(r_item.off_value);
                sel_lo = SW'(base_min_off);
                sel_hi = SW'(base_max_off);
            end
            default: begin
                sel_v  = SW'(r_item.on_value) + fs_s - SW'(r_item.off_value);
                sel_lo = (base_min_off < base_min_on) ? fs_s
                         : SW'(base_min_on) + fs_s - SW'(base_min_off);
                sel_hi = (base_max_off < base_max_on) ? fs_s
                         : SW'(base_max_on) + fs_s - SW'(base_max_off);
            end
        endcase
    end

    // span checks
    assign calc_num  = r_v - r_lo;
    assign calc_den  = r_hi - r_lo;
    assign calc_zero = (calc_den <= 0) || (calc_num <= 0);
    assign calc_sat  = (calc_num >= calc_den);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (r_item.operation == rscn_pkg::OP_CAL || rd_not_cal) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                if (calc_zero || calc_sat) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= rscn_pkg::MODE_ON;
            r_fs        <= RW'(rscn_pkg::FULL_SCALE_RESET);
            r_on_valid  <= 1'b0;
            r_off_valid <= 1'b0;
            r_on_ent    <= '0;
            r_off_ent   <= '0;
            r_bat_ent   <= '0;
            r_div_go    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_div_go <= (r_state == S_MUL);
            // configuration word
            if (i_cfg.valid) begin
                unique case (i_cfg.data.index)
                    rscn_pkg::CFG_READ_MODE:  r_mode <= i_cfg.data.value[rscn_pkg::MODE_W-1:0];
                    rscn_pkg::CFG_FULL_SCALE: r_fs   <= i_cfg.data.value[RW-1:0];
                    default: ;
                endcase
            end
            // entry and table valid bits
            if (cal_now) begin
                r_bat_ent[r_idx] <= 1'b1;
                if (commit_on) begin
                    r_on_valid      <= 1'b1;
                    r_on_ent[r_idx] <= 1'b1;
                end
                if (commit_off) begin
                    r_off_valid      <= 1'b1;
                    r_off_ent[r_idx] <= 1'b1;
                end
            end
            // output register
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // calibration memory: registered read at acceptance, write back in the following cycle
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd <= r_mem[in_idx];
        end
        if (cal_now) begin
            r_mem[r_idx] <= wr_entry;
        end
    end

    // fill value of a table, taken when it is first committed
    always_ff @(posedge i_clk) begin
        if (cal_now && commit_on && !r_on_valid) begin
            r_fill_on <= r_fs;
        end
        if (cal_now && commit_off && !r_off_valid) begin
            r_fill_off <= r_fs;
        end
    end

    // item and datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item     <= i_in.data;
            r_idx      <= in_idx;
            r_in_range <= in_range;
        end
        if (r_state == S_READ) begin
            r_v     <= sel_v;
            r_lo    <= sel_lo;
            r_hi    <= sel_hi;
            r_level <= '0;
            if (r_item.operation == rscn_pkg::OP_CAL) begin
                r_status <= rscn_pkg::STATUS_CAL;
            end else if (rd_not_cal) begin
                r_status <= rscn_pkg::STATUS_NOT_CAL;
            end else begin
                r_status <= rscn_pkg::STATUS_OK;
            end
        end
        if (r_state == S_CALC) begin
            r_num <= calc_num[NW-1:0];
            r_den <= calc_den[NW-1:0];
            if (!calc_zero && calc_sat) begin
                r_level <= LW'(rscn_pkg::FULL_LEVEL);
            end
        end
        if (r_state == S_MUL) begin
            r_prod <= PW'(r_num) * PW'(rscn_pkg::FULL_LEVEL);
        end
        if (r_state == S_DIV && div_done) begin
            r_level <= div_quot;
        end
        if (out_load) begin
            r_out.out_channel <= r_item.channel;
            r_out.level       <= r_level;
            r_out.status      <= r_status;
        end
    end

    // scaling divider
    rscn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_prod),
        .i_divisor  (r_den),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );
endmodule

@@ design/rscn_checker.sv @@
// port-level checks for the reflectance sensor calibrate and normalize block
`timescale 1ns / 1ps

module rscn_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input rscn_pkg::t_result i_out_data
);
    // a pending result word stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped before it was taken");

    // one word in work at a time
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken again right after acceptance");

    // status is one of the three codes
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.status == rscn_pkg::STATUS_OK ||
                         i_out_data.status == rscn_pkg::STATUS_NOT_CAL ||
                         i_out_data.status == rscn_pkg::STATUS_CAL))
        else $error("bad status code");

    // only ok reads carry a level
    a_level_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.status != rscn_pkg::STATUS_OK |-> i_out_data.level == '0)
        else $error("level set on a word that is not an ok read");

    // level stays within full level
    a_level_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data.level <= rscn_pkg::LEVEL_W'(rscn_pkg::FULL_LEVEL))
        else $error("level above full level");
endmodule

bind reflectance_sensor_calibrate_normalize rscn_checker u_rscn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

@@ tb/reflectance_sensor_calibrate_normalize_test.sv @@
// testbench: calibration batches and normalized reads checked against a built-in predictor
`timescale 1ns / 1ps

module reflectance_sensor_calibrate_normalize_test;

    localparam int NCH         = rscn_pkg::DEF_NUM_CHANNELS;
    localparam int RAW_MAX     = (1 << rscn_pkg::RAW_W) - 1;
    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD   = 400;
    localparam int TAIL_CYCLES = 40;
    localparam int PHASE_WORDS = 175;
    // unused mode code, acts as combined
    localparam logic [rscn_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

    logic i_clk;
    logic i_rst_n;

    rscn_chan_if #(.T(rscn_pkg::t_item))   in_ch ();
    rscn_chan_if #(.T(rscn_pkg::t_result)) out_ch ();
    rscn_chan_if #(.T(rscn_pkg::t_cfg_wr)) cfg_ch ();

    reflectance_sensor_calibrate_normalize DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // predictor copy of the calibration memory and registers
    bit [rscn_pkg::RAW_W-1:0]   floor_on [NCH];
    bit [rscn_pkg::RAW_W-1:0]   ceil_on [NCH];
    bit [rscn_pkg::RAW_W-1:0]   floor_off [NCH];
    bit [rscn_pkg::RAW_W-1:0]   ceil_off [NCH];
    bit [rscn_pkg::RAW_W-1:0]   run_lo_on [NCH];
    bit [rscn_pkg::RAW_W-1:0]   run_hi_on [NCH];
    bit [rscn_pkg::RAW_W-1:0]   run_lo_off [NCH];
    bit [rscn_pkg::RAW_W-1:0]   run_hi_off [NCH];
    bit [rscn_pkg::COUNT_W-1:0] run_len [NCH];
    bit                         on_tbl_ok;
    bit                         off_tbl_ok;
    bit [rscn_pkg::MODE_W-1:0]  cur_mode;
    bit [rscn_pkg::RAW_W-1:0]   cur_fs;

    rscn_pkg::t_item   words_to_send[$];
    rscn_pkg::t_result predicted_results[$];

    bit in_taken;
    bit hold_req;
    int hold_left;
    int in_gap;
    int out_gap;
    int idle_pct;
    int quiet_cycles;
    int fail_count;
    int words_in;
    int results_in;
    int n_ok;
    int n_full;
    int n_not_cal;
    int n_cal;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // map a reading onto 0..1000 against a range, clamped
    function automatic logic [rscn_pkg::LEVEL_W-1:0] scale_level(int v, int lo, int hi);
        int span;
        int num;
        int q;
        span = hi - lo;
        num  = v - lo;
        if (span <= 0 || num <= 0) begin
            return '0;
        end
        q = num * rscn_pkg::FULL_LEVEL / span;
        return (q > rscn_pkg::FULL_LEVEL) ? rscn_pkg::LEVEL_W'(rscn_pkg::FULL_LEVEL)
                                          : rscn_pkg::LEVEL_W'(q);
    endfunction

    // expected result of one word, updating the predictor state
    function automatic rscn_pkg::t_result sensor_response(rscn_pkg::t_item w);
        rscn_pkg::t_result r;
        int      c;
        int      k;
        int      fs;
        int      v;
        int      lo;
        int      hi;
        bit      first;
        bit      use_on;
        bit      use_off;
        c       = w.channel;
        fs      = cur_fs;
        use_on  = cur_mode != rscn_pkg::MODE_OFF;
        use_off = cur_mode != rscn_pkg::MODE_ON;
        r.out_channel = w.channel;
        r.level       = '0;
        if (w.operation == rscn_pkg::OP_CAL) begin
            r.status = rscn_pkg::STATUS_CAL;
            first = run_len[c] == 0;
            if (first || w.on_value < run_lo_on[c]) run_lo_on[c] = w.on_value;
            if (first || w.on_value > run_hi_on[c]) run_hi_on[c] = w.on_value;
            if (first || w.off_value < run_lo_off[c]) run_lo_off[c] = w.off_value;
            if (first || w.off_value > run_hi_off[c]) run_hi_off[c] = w.off_value;
            run_len[c] = run_len[c] + 1'b1;
            // batch end: widen the selected tables, filling them on first use
            if (run_len[c] >= rscn_pkg::BATCH_LENGTH) begin
                run_len[c] = '0;
                if (use_on) begin
                    if (!on_tbl_ok) begin
                        for (k = 0; k < NCH; k++) begin
                            floor_on[k] = cur_fs;
                            ceil_on[k]  = '0;
                        end
                        on_tbl_ok = 1'b1;
                    end
                    if (run_lo_on[c] > ceil_on[c]) ceil_on[c] = run_lo_on[c];
                    if (run_hi_on[c] < floor_on[c]) floor_on[c] = run_hi_on[c];
                end
                if (use_off) begin
                    if (!off_tbl_ok) begin
                        for (k = 0; k < NCH; k++) begin
                            floor_off[k] = cur_fs;
                            ceil_off[k]  = '0;
                        end
                        off_tbl_ok = 1'b1;
                    end
                    if (run_lo_off[c] > ceil_off[c]) ceil_off[c] = run_lo_off[c];
                    if (run_hi_off[c] < floor_off[c]) floor_off[c] = run_hi_off[c];
                end
            end
        end else if ((use_on && !on_tbl_ok) || (use_off && !off_tbl_ok)) begin
            r.status = rscn_pkg::STATUS_NOT_CAL;
        end else begin
            r.status = rscn_pkg::STATUS_OK;
            case (cur_mode)
                rscn_pkg::MODE_ON: begin
                    r.level = scale_level(w.on_value, floor_on[c], ceil_on[c]);
                end
                rscn_pkg::MODE_OFF: begin
                    r.level = scale_level(w.off_value, floor_off[c], ceil_off[c]);
                end
                default: begin
                    // combined: on plus full scale minus off, range built alike
                    v  = int'(w.on_value) + fs - int'(w.off_value);
                    lo = (floor_off[c] < floor_on[c]) ? fs :
                         int'(floor_on[c]) + fs - int'(floor_off[c]);
                    hi = (ceil_off[c] < ceil_on[c]) ? fs :
                         int'(ceil_on[c]) + fs - int'(ceil_off[c]);
                    r.level = scale_level(v, lo, hi);
                end
            endcase
        end
        return r;
    endfunction

    function automatic void add_word(logic op, int ch, int on_v, int off_v);
        rscn_pkg::t_item w;
        w.operation = op;
        w.channel   = rscn_pkg::CH_W'(ch);
        w.on_value  = rscn_pkg::RAW_W'(on_v);
        w.off_value = rscn_pkg::RAW_W'(off_v);
        words_to_send.push_back(w);
    endfunction

    // raw reading with the extremes weighted up
    function automatic int raw_value();
        case ($urandom_range(7))
            0: return 0;
            1: return RAW_MAX;
            default: return $urandom_range(RAW_MAX);
        endcase
    endfunction

    // start of a dark, bright or arbitrary band of samples
    function automatic int band_base();
        case ($urandom_range(2))
            0: return $urandom_range(500);
            1: return $urandom_range(3900, 3000);
            default: return $urandom_range(3895);
        endcase
    endfunction

    function automatic int sample_near(int base, int spread);
        int v;
        v = base + $urandom_range(spread);
        return (v > RAW_MAX) ? RAW_MAX : v;
    endfunction

    // mostly whole batches on one channel with reads after, some loose words
    task automatic queue_random(input int n);
        int made;
        int pick;
        int c;
        int k;
        int reads;
        int base_on;
        int base_off;
        int spread;
        made = 0;
        while (made < n) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                c        = $urandom_range(NCH - 1);
                base_on  = band_base();
                base_off = band_base();
                spread   = $urandom_range(200);
                for (k = 0; k < rscn_pkg::BATCH_LENGTH; k++) begin
                    add_word(rscn_pkg::OP_CAL, c, sample_near(base_on, spread),
                             sample_near(base_off, spread));
                end
                reads = $urandom_range(3);
                for (k = 0; k < reads; k++) begin
                    add_word(rscn_pkg::OP_READ, c, raw_value(), raw_value());
                end
                made += rscn_pkg::BATCH_LENGTH + reads;
            end else if (pick < 90) begin
                add_word(rscn_pkg::OP_READ, $urandom_range(NCH - 1), raw_value(), raw_value());
                made++;
            end else begin
                add_word(rscn_pkg::OP_CAL, $urandom_range(NCH - 1), raw_value(), raw_value());
                made++;
            end
        end
    endtask

    task automatic write_reg(input logic [rscn_pkg::CFG_IDX_W-1:0] idx, input int val);
        rscn_pkg::t_cfg_wr wr;
        wr.index = idx;
        wr.value = rscn_pkg::CFG_DATA_W'(val);
        @(negedge i_clk);
        cfg_ch.data  <= wr;
        cfg_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // sender holds back until every predicted result has come out
    task automatic wait_drained();
        @(posedge i_clk);
        while (words_to_send.size() != 0 || in_ch.valid || predicted_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // input word driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            if (in_gap > 0) begin
                in_gap--;
                in_ch.valid <= 1'b0;
            end else if (words_to_send.size() != 0 && idle_pct != 0 &&
                         $urandom_range(99) < idle_pct) begin
                in_gap = $urandom_range(16, 1) - 1;
                in_ch.valid <= 1'b0;
            end else if (words_to_send.size() != 0) begin
                in_ch.data  <= words_to_send.pop_front();
                in_ch.valid <= 1'b1;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // result ready driver, with random stalls and one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_req || hold_left > 0) begin
            if (hold_req) begin
                hold_left = LONG_HOLD;
                hold_req  = 1'b0;
            end
            hold_left--;
            out_ch.ready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap--;
            out_ch.ready <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            out_gap = $urandom_range(16, 1) - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // monitor: register writes, accepted words, result checks, watchdog
    always @(posedge i_clk) begin : monitor
        rscn_pkg::t_result want;
        rscn_pkg::t_result got;
        if (i_rst_n) begin
            quiet_cycles++;
            if (cfg_ch.valid && cfg_ch.ready) begin
                quiet_cycles = 0;
                case (cfg_ch.data.index)
                    rscn_pkg::CFG_READ_MODE:  cur_mode = cfg_ch.data.value[rscn_pkg::MODE_W-1:0];
                    rscn_pkg::CFG_FULL_SCALE: cur_fs   = cfg_ch.data.value[rscn_pkg::RAW_W-1:0];
                endcase
            end
            in_taken = in_ch.valid && in_ch.ready;
            if (in_taken) begin
                predicted_results.push_back(sensor_response(in_ch.data));
                words_in++;
                quiet_cycles = 0;
            end
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                quiet_cycles = 0;
                results_in++;
                if (predicted_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: unexpected result ch %0d level %0d status %0d",
                                 $time, got.out_channel, got.level, got.status);
                    end
                end else begin
                    want = predicted_results.pop_front();
                    if (got.out_channel !== want.out_channel || got.level !== want.level ||
                        got.status !== want.status) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display({"%0t: expected ch %0d level %0d status %0d, ",
                                      "got ch %0d level %0d status %0d"},
                                     $time, want.out_channel, want.level, want.status,
                                     got.out_channel, got.level, got.status);
                        end
                    end
                    case (want.status)
                        rscn_pkg::STATUS_OK: begin
                            n_ok++;
                            if (want.level == rscn_pkg::FULL_LEVEL) n_full++;
                        end
                        rscn_pkg::STATUS_NOT_CAL: n_not_cal++;
                        default: n_cal++;
                    endcase
                end
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // stimulus sequence
    initial begin : stimulus
        int k;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        idle_pct     = 0;
        cur_mode     = rscn_pkg::MODE_ON;
        cur_fs       = rscn_pkg::RAW_W'(rscn_pkg::FULL_SCALE_RESET);
        on_tbl_ok    = 1'b0;
        off_tbl_ok   = 1'b0;
        for (k = 0; k < NCH; k++) begin
            floor_on[k]   = rscn_pkg::RAW_W'(rscn_pkg::FULL_SCALE_RESET);
            ceil_on[k]    = '0;
            floor_off[k]  = rscn_pkg::RAW_W'(rscn_pkg::FULL_SCALE_RESET);
            ceil_off[k]   = '0;
            run_lo_on[k]  = '0;
            run_hi_on[k]  = '0;
            run_lo_off[k] = '0;
            run_hi_off[k] = '0;
            run_len[k]    = '0;
        end

        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // emitters on, widest full scale
        write_reg(rscn_pkg::CFG_READ_MODE, rscn_pkg::MODE_ON);
        write_reg(rscn_pkg::CFG_FULL_SCALE, RAW_MAX);
        // read before any calibration
        add_word(rscn_pkg::OP_READ, 0, RAW_MAX, RAW_MAX);
        // a dark batch then a bright batch on the last channel
        for (k = 0; k < rscn_pkg::BATCH_LENGTH; k++) begin
            add_word(rscn_pkg::OP_CAL, NCH - 1, k * 20, RAW_MAX - k);
        end
        for (k = 0; k < rscn_pkg::BATCH_LENGTH; k++) begin
            add_word(rscn_pkg::OP_CAL, NCH - 1, RAW_MAX - k * 30, k);
        end
        // below range, above range, mid range, then an untouched channel
        add_word(rscn_pkg::OP_READ, NCH - 1, 0, 0);
        add_word(rscn_pkg::OP_READ, NCH - 1, RAW_MAX, 0);
        add_word(rscn_pkg::OP_READ, NCH - 1, 2000, 0);
        add_word(rscn_pkg::OP_READ, 0, 2000, 0);
        idle_pct = 25;
        queue_random(PHASE_WORDS - 25);
        wait_drained();

        // emitters off; the off table is not yet calibrated
        write_reg(rscn_pkg::CFG_READ_MODE, rscn_pkg::MODE_OFF);
        write_reg(rscn_pkg::CFG_FULL_SCALE, 2000);
        add_word(rscn_pkg::OP_READ, 3, 1000, 1000);
        idle_pct = 10;
        queue_random(PHASE_WORDS);
        // result side holds off long enough to back up the input
        @(posedge i_clk);
        hold_req = 1'b1;
        wait_drained();

        // combined mode at a full scale of 1
        write_reg(rscn_pkg::CFG_READ_MODE, rscn_pkg::MODE_BOTH);
        write_reg(rscn_pkg::CFG_FULL_SCALE, 1);
        idle_pct = 40;
        queue_random(PHASE_WORDS);
        wait_drained();

        // spare mode code at the largest full scale
        write_reg(rscn_pkg::CFG_READ_MODE, MODE_SPARE);
        write_reg(rscn_pkg::CFG_FULL_SCALE, RAW_MAX);
        idle_pct = 20;
        queue_random(PHASE_WORDS);
        wait_drained();

        // combined mode at reset full scale, no idling on either side
        write_reg(rscn_pkg::CFG_READ_MODE, rscn_pkg::MODE_BOTH);
        write_reg(rscn_pkg::CFG_FULL_SCALE, rscn_pkg::FULL_SCALE_RESET);
        idle_pct = 0;
        queue_random(PHASE_WORDS);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("%0d words sent over five mode and full-scale settings, %0d results checked",
                 words_in, results_in);
        $display("reads ok %0d (%0d at full level), uncalibrated %0d, samples %0d, failures %0d",
                 n_ok, n_full, n_not_cal, n_cal, fail_count);
        if (fail_count == 0 && predicted_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
